@@ rtl/icre_pkg.sv @@
package icre_pkg;

  localparam int MAX_DIM    = 256;
  localparam int PIXEL_BITS = 24;
  localparam int DIM_BITS   = $clog2(MAX_DIM);
  localparam int SIZE_BITS  = DIM_BITS + 1;
  localparam int ADDR_BITS  = 2 * DIM_BITS;
  localparam int CFG_BITS   = SIZE_BITS;
  localparam int IDX_BITS   = 3;

  typedef logic [DIM_BITS-1:0]   dim_t;
  typedef logic [SIZE_BITS-1:0]  size_t;
  typedef logic [ADDR_BITS-1:0]  addr_t;
  typedef logic [PIXEL_BITS-1:0] pixel_t;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_FETCH = 1'b1
  } op_t;

  typedef enum logic {
    MODE_CROP   = 1'b0,
    MODE_ROTATE = 1'b1
  } mode_t;

  typedef enum logic [IDX_BITS-1:0] {
    CFG_IMAGE_WIDTH  = 3'd0,
    CFG_IMAGE_HEIGHT = 3'd1,
    CFG_MODE         = 3'd2,
    CFG_CROP_X       = 3'd3,
    CFG_CROP_Y       = 3'd4,
    CFG_CROP_WIDTH   = 3'd5,
    CFG_CROP_HEIGHT  = 3'd6
  } cfg_idx_t;

  // sizes kept as clamped last index
  typedef struct packed {
    mode_t mode;
    dim_t  crop_x;
    dim_t  crop_y;
    dim_t  img_w_m1;
    dim_t  img_h_m1;
    dim_t  crop_w_m1;
    dim_t  crop_h_m1;
  } cfg_t;

  typedef struct packed {
    dim_t out_col;
    dim_t out_row;
    logic row_end;
    logic image_end;
    logic bounds_error;
  } meta_t;

  // zero acts as one, above max acts as max
  function automatic dim_t size_to_last(input size_t v);
    dim_t res;
    if (v == '0) begin
      res = '0;
    end else if (v > size_t'(MAX_DIM)) begin
      res = dim_t'(MAX_DIM - 1);
    end else begin
      res = dim_t'(v - size_t'(1));
    end
    return res;
  endfunction

endpackage

@@ rtl/image_crop_rotate_engine_unit.sv @@
// a fetch word passes the read stage, then the output register, to out_valid
// throughput: one word per cycle, load or fetch, while out_ready does not stall,
// set by the single frame memory port; a load word gives no result
// reset clears the raster counters and the registers to their defaults
// the frame store is not cleared, a fetch of a never loaded pixel is undefined
module image_crop_rotate_engine_unit
  import icre_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_op,
  input  logic [23:0]         in_pixel_in,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [23:0]         out_pixel_out,
  output logic [7:0]          out_col,
  output logic [7:0]          out_row,
  output logic                out_row_end,
  output logic                out_image_end,
  output logic                out_bounds_error,
  input  logic                cfg_we,
  input  logic [IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0] cfg_data
);

  cfg_t   cfg;
  logic   in_accept;
  logic   mem_we, mem_re;
  addr_t  mem_addr;
  meta_t  meta;
  pixel_t rd_data;

  logic   s1_valid_r, s1_valid_nxt;
  meta_t  s1_meta_r, s1_meta_nxt;
  logic   s1_adv;
  logic   out_valid_r, out_valid_nxt;
  meta_t  out_meta_r, out_meta_nxt;
  pixel_t out_pixel_r, out_pixel_nxt;

  icre_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  icre_addr_gen u_addr (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (in_accept),
    .op       (op_t'(in_op)),
    .cfg      (cfg),
    .mem_we   (mem_we),
    .mem_re   (mem_re),
    .mem_addr (mem_addr),
    .meta     (meta)
  );

  icre_frame_ram u_ram (
    .clk     (clk),
    .we      (mem_we),
    .re      (mem_re),
    .addr    (mem_addr),
    .wr_data (pixel_t'(in_pixel_in)),
    .rd_data (rd_data)
  );

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s1_adv;
  assign in_accept = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_meta_nxt  = s1_meta_r;
    if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    if (mem_re) begin
      s1_valid_nxt = 1'b1;
      s1_meta_nxt  = meta;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_meta_nxt  = out_meta_r;
    out_pixel_nxt = out_pixel_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
      out_meta_nxt  = s1_meta_r;
      out_pixel_nxt = s1_meta_r.bounds_error ? '0 : rd_data;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_meta_r   <= s1_meta_nxt;
    out_meta_r  <= out_meta_nxt;
    out_pixel_r <= out_pixel_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_out    = out_pixel_r;
  assign out_col          = out_meta_r.out_col;
  assign out_row          = out_meta_r.out_row;
  assign out_row_end      = out_meta_r.row_end;
  assign out_image_end    = out_meta_r.image_end;
  assign out_bounds_error = out_meta_r.bounds_error;

  a_fetch_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_op == OP_FETCH) |=> s1_valid_r)
    else $error("fetch word did not reach the read stage");

  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_meta_r)))
    else $error("stalled read stage lost its word");

  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_op == OP_LOAD && !s1_valid_r) |=> !s1_valid_r)
    else $error("load word produced a result");

  a_err_zero_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_meta_r.bounds_error) |-> (out_pixel_r == '0))
    else $error("out of range pixel not zero");

  a_image_end_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_meta_r.image_end) |-> out_meta_r.row_end)
    else $error("image end without row end");

endmodule

@@ rtl/icre_cfg_regs.sv @@
module icre_cfg_regs
  import icre_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0] cfg_data,
  output cfg_t                cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_IMAGE_WIDTH:  cfg_nxt.img_w_m1  = size_to_last(size_t'(cfg_data));
        CFG_IMAGE_HEIGHT: cfg_nxt.img_h_m1  = size_to_last(size_t'(cfg_data));
        CFG_MODE:         cfg_nxt.mode      = mode_t'(cfg_data[0]);
        CFG_CROP_X:       cfg_nxt.crop_x    = cfg_data[DIM_BITS-1:0];
        CFG_CROP_Y:       cfg_nxt.crop_y    = cfg_data[DIM_BITS-1:0];
        CFG_CROP_WIDTH:   cfg_nxt.crop_w_m1 = size_to_last(size_t'(cfg_data));
        CFG_CROP_HEIGHT:  cfg_nxt.crop_h_m1 = size_to_last(size_t'(cfg_data));
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode      <= MODE_CROP;
      cfg_r.crop_x    <= '0;
      cfg_r.crop_y    <= '0;
      cfg_r.img_w_m1  <= dim_t'(MAX_DIM - 1);
      cfg_r.img_h_m1  <= dim_t'(MAX_DIM - 1);
      cfg_r.crop_w_m1 <= dim_t'(MAX_DIM - 1);
      cfg_r.crop_h_m1 <= dim_t'(MAX_DIM - 1);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ rtl/icre_addr_gen.sv @@
module icre_addr_gen
  import icre_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  accept,
  input  op_t   op,
  input  cfg_t  cfg,
  output logic  mem_we,
  output logic  mem_re,
  output addr_t mem_addr,
  output meta_t meta
);

  dim_t load_row_r, load_col_r, emit_row_r, emit_col_r;
  dim_t load_row_nxt, load_col_nxt, emit_row_nxt, emit_col_nxt;

  logic            fetch;
  logic [DIM_BITS:0] crop_sr, crop_sc;
  logic            err;
  dim_t            src_row, src_col;
  dim_t            ow_m1, oh_m1;
  logic            load_rend, load_iend, emit_rend, emit_iend;

  assign fetch = (op == OP_FETCH);

  always_comb begin
    crop_sr = {1'b0, cfg.crop_y} + {1'b0, emit_row_r};
    crop_sc = {1'b0, cfg.crop_x} + {1'b0, emit_col_r};
    if (cfg.mode == MODE_CROP) begin
      err     = (crop_sr > {1'b0, cfg.img_h_m1}) || (crop_sc > {1'b0, cfg.img_w_m1});
      src_row = crop_sr[DIM_BITS-1:0];
      src_col = crop_sc[DIM_BITS-1:0];
      ow_m1   = cfg.crop_w_m1;
      oh_m1   = cfg.crop_h_m1;
    end else begin
      err     = (emit_col_r > cfg.img_h_m1) || (emit_row_r > cfg.img_w_m1);
      src_row = cfg.img_h_m1 - emit_col_r;
      src_col = emit_row_r;
      ow_m1   = cfg.img_h_m1;
      oh_m1   = cfg.img_w_m1;
    end
  end

  // raster advance, counters past the end count as at the end
  always_comb begin
    load_rend    = (load_col_r >= cfg.img_w_m1);
    load_iend    = load_rend && (load_row_r >= cfg.img_h_m1);
    emit_rend    = (emit_col_r >= ow_m1);
    emit_iend    = emit_rend && (emit_row_r >= oh_m1);
    load_row_nxt = load_row_r;
    load_col_nxt = load_col_r;
    emit_row_nxt = emit_row_r;
    emit_col_nxt = emit_col_r;
    if (accept && !fetch) begin
      load_col_nxt = load_rend ? '0 : load_col_r + dim_t'(1);
      if (load_rend) begin
        load_row_nxt = load_iend ? '0 : load_row_r + dim_t'(1);
      end
    end
    if (accept && fetch) begin
      emit_col_nxt = emit_rend ? '0 : emit_col_r + dim_t'(1);
      if (emit_rend) begin
        emit_row_nxt = emit_iend ? '0 : emit_row_r + dim_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_row_r <= '0;
      load_col_r <= '0;
      emit_row_r <= '0;
      emit_col_r <= '0;
    end else begin
      load_row_r <= load_row_nxt;
      load_col_r <= load_col_nxt;
      emit_row_r <= emit_row_nxt;
      emit_col_r <= emit_col_nxt;
    end
  end

  assign mem_we   = accept && !fetch;
  assign mem_re   = accept && fetch;
  assign mem_addr = fetch ? {src_row, src_col} : {load_row_r, load_col_r};

  assign meta.out_col      = emit_col_r;
  assign meta.out_row      = emit_row_r;
  assign meta.row_end      = emit_rend;
  assign meta.image_end    = emit_iend;
  assign meta.bounds_error = err;

endmodule

@@ rtl/icre_frame_ram.sv @@
module icre_frame_ram
  import icre_pkg::*;
(
  input  logic   clk,
  input  logic   we,
  input  logic   re,
  input  addr_t  addr,
  input  pixel_t wr_data,
  output pixel_t rd_data
);

  pixel_t mem [MAX_DIM*MAX_DIM];
  pixel_t rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wr_data;
    end
    if (re) begin
      rd_data_r <= mem[addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ tb/image_crop_rotate_engine_unit_tb.sv @@
module image_crop_rotate_engine_unit_tb;
  import icre_pkg::*;

  localparam int WORD_TARGET = 1350;
  localparam int FETCH_CAP   = 80;

  typedef struct {
    pixel_t     pixel;
    logic [7:0] col;
    logic [7:0] row;
    logic       row_end;
    logic       image_end;
    logic       bounds_error;
  } out_pixel_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic                in_op;
  logic [23:0]         in_pixel_in;
  logic                out_valid;
  logic                out_ready;
  logic [23:0]         out_pixel_out;
  logic [7:0]          out_col;
  logic [7:0]          out_row;
  logic                out_row_end;
  logic                out_image_end;
  logic                out_bounds_error;
  logic                cfg_we;
  logic [IDX_BITS-1:0] cfg_index;
  logic [CFG_BITS-1:0] cfg_data;

  image_crop_rotate_engine_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_pixel_in      (in_pixel_in),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pixel_out    (out_pixel_out),
    .out_col          (out_col),
    .out_row          (out_row),
    .out_row_end      (out_row_end),
    .out_image_end    (out_image_end),
    .out_bounds_error (out_bounds_error),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // shadow copy of registers, raster counters and frame store
  logic [8:0] img_w_q, img_h_q, crop_w_q, crop_h_q;
  logic [7:0] crop_x_q, crop_y_q;
  mode_t      mode_q;
  int         load_r, load_c, emit_r, emit_c;
  pixel_t     frame_mem [0:65535];
  bit         frame_written [0:65535];

  out_pixel_t pending_pixels [$];

  int words_sent, loads_sent, fetches_sent, cfg_writes;
  int results_checked, oob_seen, mismatches;
  bit idle_on;
  int tx_gap_pct, rx_stall_pct, rx_hold;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int eff_size(logic [8:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  function automatic void out_dims(output int w, output int h);
    if (mode_q == MODE_CROP) begin
      w = eff_size(crop_w_q);
      h = eff_size(crop_h_q);
    end else begin
      w = eff_size(img_h_q);
      h = eff_size(img_w_q);
    end
  endfunction

  function automatic void locate_source(output int sr, output int sc, output bit oob);
    int iw, ih;
    iw = eff_size(img_w_q);
    ih = eff_size(img_h_q);
    if (mode_q == MODE_CROP) begin
      sr  = crop_y_q + emit_r;
      sc  = crop_x_q + emit_c;
      oob = (sr >= ih) || (sc >= iw);
    end else begin
      oob = (emit_c >= ih) || (emit_r >= iw);
      sr  = oob ? 0 : ih - 1 - emit_c;
      sc  = emit_r;
    end
  endfunction

  function automatic void advance_raster(inout int r, inout int c, input int w, input int h,
                                         output bit rend, output bit iend);
    rend = (c >= w - 1);
    iend = rend && (r >= h - 1);
    if (rend) begin
      c = 0;
      r = iend ? 0 : r + 1;
    end else begin
      c++;
    end
  endfunction

  function automatic void apply_word(op_t op, pixel_t px);
    out_pixel_t res;
    int         sr, sc, ow, oh;
    bit         oob, rend, iend;
    if (op == OP_LOAD) begin
      frame_mem[load_r * MAX_DIM + load_c]     = px;
      frame_written[load_r * MAX_DIM + load_c] = 1'b1;
      advance_raster(load_r, load_c, eff_size(img_w_q), eff_size(img_h_q), rend, iend);
      loads_sent++;
    end else begin
      locate_source(sr, sc, oob);
      out_dims(ow, oh);
      res.pixel        = oob ? '0 : frame_mem[sr * MAX_DIM + sc];
      res.col          = 8'(emit_c);
      res.row          = 8'(emit_r);
      advance_raster(emit_r, emit_c, ow, oh, rend, iend);
      res.row_end      = rend;
      res.image_end    = iend;
      res.bounds_error = oob;
      pending_pixels.push_back(res);
      fetches_sent++;
    end
  endfunction

  function automatic void check_field(string name, logic [23:0] want, logic [23:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic pixel_t rand_pixel();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return pixel_t'($urandom());
    endcase
  endfunction

  function automatic logic [8:0] rand_size();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return '0;
    if (pick == 1) return 9'($urandom_range(257, 511));
    if (pick == 2) return 9'd256;
    return 9'($urandom_range(1, 8));
  endfunction

  function automatic logic [8:0] rand_offset();
    if ($urandom_range(0, 4) == 0) return 9'($urandom_range(0, 255));
    return 9'($urandom_range(0, 12));
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_word(op_t op, pixel_t px);
    int sr, sc, gap;
    bit oob;
    // never fetch a stored pixel that was not loaded yet
    locate_source(sr, sc, oob);
    if (op == OP_FETCH && !oob && !frame_written[sr * MAX_DIM + sc]) op = OP_LOAD;
    if (idle_on && $urandom_range(0, 99) < tx_gap_pct) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_op       <= op;
    in_pixel_in <= px;
    do @(posedge clk); while (in_ready !== 1'b1);
    apply_word(op, px);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic load_run(int n);
    repeat (n) send_word(OP_LOAD, rand_pixel());
  endtask

  task automatic fetch_run(int n);
    repeat (n) send_word(OP_FETCH, rand_pixel());
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    // margin after the last result word
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [8:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    case (idx)
      CFG_IMAGE_WIDTH:  img_w_q  = val;
      CFG_IMAGE_HEIGHT: img_h_q  = val;
      CFG_MODE:         mode_q   = mode_t'(val[0]);
      CFG_CROP_X:       crop_x_q = val[7:0];
      CFG_CROP_Y:       crop_y_q = val[7:0];
      CFG_CROP_WIDTH:   crop_w_q = val;
      CFG_CROP_HEIGHT:  crop_h_q = val;
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic test_crop_window();
    write_reg(CFG_IMAGE_WIDTH, 9'd3);
    write_reg(CFG_IMAGE_HEIGHT, 9'd2);
    write_reg(CFG_MODE, MODE_CROP);
    write_reg(CFG_CROP_X, 9'd1);
    write_reg(CFG_CROP_Y, 9'd0);
    write_reg(CFG_CROP_WIDTH, 9'd2);
    write_reg(CFG_CROP_HEIGHT, 9'd2);
    send_word(OP_LOAD, '0);
    send_word(OP_LOAD, '1);
    load_run(4);
    fetch_run(4);
    wait_drained();
  endtask

  // window hangs off the image, zero width acts as one
  task automatic test_bounds_and_clamp();
    write_reg(CFG_CROP_X, 9'd2);
    write_reg(CFG_CROP_Y, 9'd1);
    write_reg(CFG_CROP_WIDTH, 9'd0);
    write_reg(CFG_CROP_HEIGHT, 9'd3);
    fetch_run(3);
    wait_drained();
  endtask

  // shrink the image under running counters, then switch mode mid-stream
  task automatic test_rotate_midstream();
    write_reg(CFG_MODE, MODE_ROTATE);
    fetch_run(3);
    wait_drained();
    write_reg(CFG_IMAGE_HEIGHT, 9'd1);
    fetch_run(2);
    wait_drained();
    write_reg(CFG_MODE, MODE_CROP);
    fetch_run(3);
    wait_drained();
  endtask

  task automatic test_full_extent();
    write_reg(CFG_IMAGE_WIDTH, 9'h1FF);
    write_reg(CFG_IMAGE_HEIGHT, 9'd1);
    write_reg(CFG_CROP_X, 9'd0);
    write_reg(CFG_CROP_Y, 9'd0);
    write_reg(CFG_CROP_WIDTH, 9'd256);
    write_reg(CFG_CROP_HEIGHT, 9'd1);
    load_run(256);
    fetch_run(256);
    wait_drained();
    write_reg(CFG_MODE, MODE_ROTATE);
    fetch_run(256);
    wait_drained();
    write_reg(CFG_MODE, MODE_CROP);
    write_reg(CFG_CROP_X, 9'd255);
    write_reg(CFG_CROP_WIDTH, 9'd300);
    fetch_run(3);
    wait_drained();
    write_reg(CFG_CROP_Y, 9'd255);
    fetch_run(2);
    wait_drained();
  endtask

  task automatic test_random_frames();
    int ow, oh;
    bit first;
    first = 1'b1;
    while (words_sent < WORD_TARGET) begin
      wait_drained();
      if (words_sent > WORD_TARGET - 200) begin
        idle_on = 1'b0;
      end else begin
        idle_on      = ($urandom_range(0, 3) != 0);
        tx_gap_pct   = $urandom_range(5, 35);
        rx_stall_pct = $urandom_range(5, 35);
      end
      if (first || $urandom_range(0, 1)) write_reg(CFG_IMAGE_WIDTH, 9'($urandom_range(0, 8)));
      if (first || $urandom_range(0, 1)) write_reg(CFG_IMAGE_HEIGHT, 9'($urandom_range(0, 8)));
      if (first || $urandom_range(0, 1)) write_reg(CFG_MODE, 9'($urandom_range(0, 1)));
      if (first || $urandom_range(0, 1)) write_reg(CFG_CROP_X, rand_offset());
      if (first || $urandom_range(0, 1)) write_reg(CFG_CROP_Y, rand_offset());
      if (first || $urandom_range(0, 1)) write_reg(CFG_CROP_WIDTH, rand_size());
      if (first || $urandom_range(0, 1)) write_reg(CFG_CROP_HEIGHT, rand_size());
      first = 1'b0;
      if ($urandom_range(0, 6) != 0) begin
        load_run(eff_size(img_w_q) * eff_size(img_h_q));
        out_dims(ow, oh);
        fetch_run((ow * oh > FETCH_CAP) ? FETCH_CAP : ow * oh);
      end else begin
        repeat ($urandom_range(1, 30)) send_word(op_t'($urandom_range(0, 1)), rand_pixel());
      end
    end
  endtask

  always @(negedge clk) begin
    if (rx_hold != 0) begin
      rx_hold--;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 99) < rx_stall_pct) begin
      rx_hold = $urandom_range(1, 12) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : result_check
    out_pixel_t want;
    if (rst_n && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (pending_pixels.size() == 0) begin
        $error("out_pixel_out: expected no word, got %0h", out_pixel_out);
        mismatches++;
      end else begin
        want = pending_pixels.pop_front();
        check_field("out_pixel_out", want.pixel, out_pixel_out);
        check_field("out_col", want.col, out_col);
        check_field("out_row", want.row, out_row);
        check_field("out_row_end", want.row_end, out_row_end);
        check_field("out_image_end", want.image_end, out_image_end);
        check_field("out_bounds_error", want.bounds_error, out_bounds_error);
        results_checked++;
        if (want.bounds_error) oob_seen++;
      end
    end
  end

  initial begin
    int drain_cycles;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_op        = OP_LOAD;
    in_pixel_in  = '0;
    out_ready    = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = CFG_IMAGE_WIDTH;
    cfg_data     = '0;
    img_w_q      = 9'd256;
    img_h_q      = 9'd256;
    crop_w_q     = 9'd256;
    crop_h_q     = 9'd256;
    crop_x_q     = '0;
    crop_y_q     = '0;
    mode_q       = MODE_CROP;
    load_r       = 0;
    load_c       = 0;
    emit_r       = 0;
    emit_c       = 0;
    rx_hold      = 0;
    idle_on      = 1'b1;
    tx_gap_pct   = 20;
    rx_stall_pct = 20;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_crop_window();
    test_bounds_and_clamp();
    test_rotate_midstream();
    test_full_extent();
    test_random_frames();

    idle_on = 1'b0;
    in_valid <= 1'b0;
    drain_cycles = 0;
    while (pending_pixels.size() != 0 && drain_cycles < 2000) begin
      @(negedge clk);
      drain_cycles++;
    end
    repeat (10) @(negedge clk);
    if (pending_pixels.size() != 0) begin
      $error("out_pixel_out: expected %0d more words, got none", pending_pixels.size());
      mismatches += pending_pixels.size();
    end
    $display("sent %0d loads and %0d fetches across %0d register writes", loads_sent,
             fetches_sent, cfg_writes);
    $display("compared %0d result words, %0d outside the image, %0d mismatches",
             results_checked, oob_seen, mismatches);
    if (mismatches == 0) begin
      $display("[image_crop_rotate_engine_unit] OK");
    end else begin
      $display("[image_crop_rotate_engine_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("[image_crop_rotate_engine_unit] ERROR");
    $finish;
  end

endmodule
